### hw/rtl/pvpe_pkg.sv
package pvpe_pkg;

  localparam int DEF_MAX_SEGMENTS  = 64;
  localparam int DEF_MIN_PERIOD_MS = 10;
  localparam int MAX_RESULTS       = 32;
  localparam int MAX_PAIRS         = MAX_RESULTS - 1;
  localparam int PAIR_CNT_W        = $clog2(MAX_RESULTS);

  localparam int DUR_W    = 16;
  localparam int INT_W    = 8;
  localparam int SCALE_W  = 5;
  localparam int SCALED_W = 12;
  localparam int MAX_SCALE = 16;

  localparam int APB_AW = 2;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-1:0] ADDR_PULSE_SCALE = 2'd0;

  typedef struct packed {
    logic load_in;
    logic emit_single;
    logic emit_pulse;
    logic emit_status;
  } pvpe_cmd_t;

  typedef struct packed {
    logic dur_zero;
    logic full;
    logic scaled_zero;
    logic scaled_ge;
    logic pulse_ok;
    logic slot_free;
  } pvpe_stat_t;

endpackage

### hw/rtl/pvpe_if.sv
interface pvpe_in_if import pvpe_pkg::*;;
  logic             valid;
  logic             ready;
  logic [DUR_W-1:0] duration_ms;
  logic [INT_W-1:0] intensity;
  logic             last_pair;

  modport source (output valid, duration_ms, intensity, last_pair, input ready);
  modport sink (input valid, duration_ms, intensity, last_pair, output ready);
endinterface

interface pvpe_out_if import pvpe_pkg::*;;
  logic             valid;
  logic             ready;
  logic [DUR_W-1:0] on_ms;
  logic [DUR_W-1:0] off_ms;
  logic             pair_valid;
  logic             pattern_full;
  logic             last_of_run;

  modport source (output valid, on_ms, off_ms, pair_valid, pattern_full, last_of_run,
                  input ready);
  modport sink (input valid, on_ms, off_ms, pair_valid, pattern_full, last_of_run,
                output ready);
endinterface

### hw/rtl/pwm_vibe_pattern_expander.sv
// Vibration pattern expander. Takes one (duration_ms, intensity, last_pair)
// request per input transaction and returns its on/off segment pairs, then one
// status transaction (pair_valid = 0, last_of_run = 1). The PWM period is
// MIN_PERIOD_MS * pulse_scale; a pulse train pair is emitted per period that
// fits in the duration, at most 31 per request and only while the pattern
// store has room for two more segments. A request with last_pair set clears
// the segment count after its status transaction. Each request is loaded, then
// decided, then emits its pairs and status, paced by the output register; the
// pulse train is produced by one compare-and-subtract of the period per cycle
// unless the output stalls. Input is taken only between requests. pulse_scale
// (APB offset 0x0, reset 1) must be written while idle; 0 acts as 1 and
// values above 16 act as 16.
module pwm_vibe_pattern_expander
  import pvpe_pkg::*;
#(
  parameter int MAX_SEGMENTS  = DEF_MAX_SEGMENTS,
  parameter int MIN_PERIOD_MS = DEF_MIN_PERIOD_MS
) (
  input  logic              clk,
  input  logic              rst,
  pvpe_in_if.sink           in_ch,
  pvpe_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [SCALE_W-1:0] pulse_scale;
  logic [SCALE_W-1:0] scale_eff;
  pvpe_cmd_t          cmd;
  pvpe_stat_t         stat;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_PULSE_SCALE) ? APB_DW'(pulse_scale) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_scale <= SCALE_W'(1);
    end else if (psel && penable && pwrite && pready && paddr == ADDR_PULSE_SCALE) begin
      pulse_scale <= pwdata[SCALE_W-1:0];
    end
  end

  always_comb begin
    if (pulse_scale == '0) begin
      scale_eff = SCALE_W'(1);
    end else if (pulse_scale > SCALE_W'(MAX_SCALE)) begin
      scale_eff = SCALE_W'(MAX_SCALE);
    end else begin
      scale_eff = pulse_scale;
    end
  end

  pvpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pvpe_dp #(
    .MAX_SEGMENTS  (MAX_SEGMENTS),
    .MIN_PERIOD_MS (MIN_PERIOD_MS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .scale        (scale_eff),
    .duration_ms  (in_ch.duration_ms),
    .intensity    (in_ch.intensity),
    .last_pair    (in_ch.last_pair),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .on_ms        (out_ch.on_ms),
    .off_ms       (out_ch.off_ms),
    .pair_valid   (out_ch.pair_valid),
    .pattern_full (out_ch.pattern_full),
    .last_of_run  (out_ch.last_of_run)
  );

endmodule

### hw/rtl/pvpe_ctrl.sv
module pvpe_ctrl
  import pvpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  pvpe_stat_t stat,
  output pvpe_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SINGLE = 3'd2;
  localparam logic [2:0] S_PULSE  = 3'd3;
  localparam logic [2:0] S_STATUS = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.dur_zero || stat.full) begin
          state_next = S_STATUS;
        end else if (stat.scaled_zero || stat.scaled_ge) begin
          state_next = S_SINGLE;
        end else begin
          state_next = S_PULSE;
        end
      end
      S_SINGLE: begin
        if (stat.slot_free) begin
          cmd.emit_single = 1'b1;
          state_next      = S_STATUS;
        end
      end
      S_PULSE: begin
        if (stat.slot_free) begin
          if (stat.pulse_ok) begin
            cmd.emit_pulse = 1'b1;
          end else begin
            state_next = S_STATUS;
          end
        end
      end
      S_STATUS: begin
        if (stat.slot_free) begin
          cmd.emit_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hw/rtl/pvpe_dp.sv
module pvpe_dp
  import pvpe_pkg::*;
#(
  parameter int MAX_SEGMENTS  = DEF_MAX_SEGMENTS,
  parameter int MIN_PERIOD_MS = DEF_MIN_PERIOD_MS
) (
  input  logic               clk,
  input  logic               rst,
  input  pvpe_cmd_t          cmd,
  output pvpe_stat_t         stat,
  input  logic [SCALE_W-1:0] scale,
  input  logic [DUR_W-1:0]   duration_ms,
  input  logic [INT_W-1:0]   intensity,
  input  logic               last_pair,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DUR_W-1:0]   on_ms,
  output logic [DUR_W-1:0]   off_ms,
  output logic               pair_valid,
  output logic               pattern_full,
  output logic               last_of_run
);

  localparam int PW = $clog2(MIN_PERIOD_MS * MAX_SCALE + 1);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  logic [DUR_W-1:0]      dur;
  logic [DUR_W-1:0]      rem;
  logic [SCALED_W-1:0]   scaled;
  logic [PW-1:0]         period;
  logic                  last;
  logic [PAIR_CNT_W-1:0] npairs;
  logic [CW-1:0]         segment_count;

  logic [INT_W+SCALE_W-1:0] scaled_in;
  logic [PW-1:0]            period_in;
  logic [CW:0]              count_p2;
  logic [CW:0]              count_p4;
  logic                     full_after;
  logic [DUR_W-1:0]         period_x;
  logic [DUR_W-1:0]         scaled_x;
  logic                     emit;

  assign scaled_in = (INT_W+SCALE_W)'(intensity) * (INT_W+SCALE_W)'(scale);
  assign period_in = PW'(MIN_PERIOD_MS) * PW'(scale);

  assign period_x = DUR_W'(period);
  assign scaled_x = DUR_W'(scaled);

  assign count_p2   = {1'b0, segment_count} + (CW+1)'(2);
  assign count_p4   = count_p2 + (CW+1)'(2);
  assign full_after = count_p4 > (CW+1)'(MAX_SEGMENTS);

  assign stat.dur_zero    = (dur == '0);
  assign stat.full        = count_p2 > (CW+1)'(MAX_SEGMENTS);
  assign stat.scaled_zero = (scaled == '0);
  assign stat.scaled_ge   = (scaled_x >= period_x);
  assign stat.pulse_ok    = (rem >= period_x) && !stat.full &&
                            (npairs < PAIR_CNT_W'(MAX_PAIRS));
  assign stat.slot_free   = !out_valid || out_ready;

  assign emit = cmd.emit_single || cmd.emit_pulse || cmd.emit_status;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dur    <= duration_ms;
      rem    <= duration_ms;
      scaled <= scaled_in[SCALED_W-1:0];
      period <= period_in;
      last   <= last_pair;
    end
    if (cmd.emit_pulse) begin
      rem <= rem - period_x;
    end

    if (cmd.emit_single) begin
      on_ms        <= stat.scaled_zero ? '0 : dur;
      off_ms       <= stat.scaled_zero ? dur : '0;
      pair_valid   <= 1'b1;
      pattern_full <= full_after;
      last_of_run  <= 1'b0;
    end else if (cmd.emit_pulse) begin
      on_ms        <= scaled_x;
      off_ms       <= period_x - scaled_x;
      pair_valid   <= 1'b1;
      pattern_full <= full_after;
      last_of_run  <= 1'b0;
    end else if (cmd.emit_status) begin
      on_ms        <= '0;
      off_ms       <= '0;
      pair_valid   <= 1'b0;
      pattern_full <= stat.full;
      last_of_run  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= '0;
      npairs        <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        npairs <= '0;
      end else if (cmd.emit_pulse) begin
        npairs <= npairs + PAIR_CNT_W'(1);
      end

      if (cmd.emit_single || cmd.emit_pulse) begin
        segment_count <= count_p2[CW-1:0];
      end else if (cmd.emit_status && last) begin
        segment_count <= '0;
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
